@@ hw/rtl/keyed_doubly_linked_list_unit_assert.svh @@
`ifndef KEYED_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH
`define KEYED_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define KDLL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define KDLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kdll_pkg.sv @@
package kdll_pkg;

    localparam int KEYS  = 1024;
    localparam int KEY_W = $clog2(KEYS);

    localparam logic [KEY_W-1:0] HEAD_KEY = '0;
    localparam logic [KEY_W-1:0] TAIL_KEY = KEY_W'(KEYS - 1);

    localparam logic [2:0] K_ADDLAST   = 3'd0;
    localparam logic [2:0] K_ADDFIRST  = 3'd1;
    localparam logic [2:0] K_ADDAFTER  = 3'd2;
    localparam logic [2:0] K_ADDBEFORE = 3'd3;
    localparam logic [2:0] K_REMOVE    = 3'd4;
    localparam logic [2:0] K_REVERSE   = 3'd5;
    localparam logic [2:0] K_READ      = 3'd6;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    typedef struct packed {
        logic [2:0]       kind;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] anchor;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] successor;
    } t_out;

    typedef enum logic [2:0] {
        S_FETCH,
        S_DECIDE,
        S_OUTER,
        S_SELF,
        S_CLEAR
    } t_step;

    typedef enum logic [1:0] {
        W_NONE,
        W_OUTER,
        W_SELF,
        W_CLEAR
    } t_wsel;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_TAKE,
        C_SKIP,
        C_REMOVE,
        C_CLR_LAST
    } t_cond;

    typedef struct packed {
        logic  fetch;
        logic  decide;
        t_wsel wsel;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uop;

    typedef struct packed {
        logic take;
        logic skip;
        logic remove;
        logic clr_last;
    } t_flags;

    // control store
    function automatic t_uop ucode(t_step pc);
        t_uop u;
        u.fetch  = 1'b0;
        u.decide = 1'b0;
        u.wsel   = W_NONE;
        u.cond   = C_ALWAYS;
        u.tgt_t  = S_FETCH;
        u.tgt_f  = S_FETCH;
        unique case (pc)
            S_FETCH: begin
                u.fetch = 1'b1;
                u.cond  = C_TAKE;
                u.tgt_t = S_DECIDE;
                u.tgt_f = S_FETCH;
            end
            S_DECIDE: begin
                u.decide = 1'b1;
                u.cond   = C_SKIP;
                u.tgt_t  = S_FETCH;
                u.tgt_f  = S_OUTER;
            end
            S_OUTER: begin
                u.wsel  = W_OUTER;
                u.cond  = C_REMOVE;
                u.tgt_t = S_FETCH;
                u.tgt_f = S_SELF;
            end
            S_SELF: begin
                u.wsel  = W_SELF;
                u.cond  = C_ALWAYS;
                u.tgt_t = S_FETCH;
                u.tgt_f = S_FETCH;
            end
            S_CLEAR: begin
                u.wsel  = W_CLEAR;
                u.cond  = C_CLR_LAST;
                u.tgt_t = S_FETCH;
                u.tgt_f = S_CLEAR;
            end
            default: begin
                u.cond  = C_ALWAYS;
                u.tgt_t = S_FETCH;
            end
        endcase
        return u;
    endfunction

endpackage

@@ hw/rtl/kdll_seq.sv @@
module kdll_seq import kdll_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uop   o_uop
);

    t_step r_pc;
    t_step n_pc;
    t_uop  uop;
    logic  hit;

    assign uop   = ucode(r_pc);
    assign o_uop = uop;

    always_comb begin
        unique case (uop.cond)
            C_ALWAYS:   hit = 1'b1;
            C_TAKE:     hit = i_flags.take;
            C_SKIP:     hit = i_flags.skip;
            C_REMOVE:   hit = i_flags.remove;
            C_CLR_LAST: hit = i_flags.clr_last;
            default:    hit = 1'b1;
        endcase
        n_pc = hit ? uop.tgt_t : uop.tgt_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

@@ hw/rtl/kdll_dp.sv @@
module kdll_dp import kdll_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_uop   i_uop,
    output t_flags o_flags,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_in    i_in_data,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_out   o_out_data
);

    logic [KEY_W-1:0] r_next_mem [KEYS];
    logic [KEY_W-1:0] r_prev_mem [KEYS];
    logic             r_pres_mem [KEYS];

    logic [2:0]       r_kind;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_anchor;
    logic [KEY_W-1:0] r_x;
    logic [KEY_W-1:0] r_q_next;
    logic [KEY_W-1:0] r_q_prev;
    logic             r_q_pk;
    logic             r_q_pa;
    logic [KEY_W-1:0] r_b;
    logic [KEY_W-1:0] r_a;
    t_out             r_res;
    t_out             r_out_data;
    logic             r_out_valid;
    logic             r_pend;
    logic             r_rev;
    logic [KEY_W-1:0] r_clr;

    logic             take;
    logic             out_free;
    logic [KEY_W-1:0] head;
    logic [KEY_W-1:0] tail;
    logic [KEY_W-1:0] rd_x;
    logic [KEY_W-1:0] fw_q;
    logic [KEY_W-1:0] bw_q;
    logic             key_ok;
    logic             anc_ok;
    logic             is_rm;
    logic [1:0]       dec_status;
    logic [KEY_W-1:0] dec_succ;
    logic [KEY_W-1:0] dec_b;
    logic [KEY_W-1:0] dec_a;
    logic [KEY_W-1:0] d_fw;
    logic [KEY_W-1:0] d_bw;
    logic             next_we;
    logic [KEY_W-1:0] next_wa;
    logic [KEY_W-1:0] next_wd;
    logic             prev_we;
    logic [KEY_W-1:0] prev_wa;
    logic [KEY_W-1:0] prev_wd;
    logic             pres_we;
    logic [KEY_W-1:0] pres_wa;
    logic             pres_wd;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(i_uop.fetch && (!r_pend || out_free));
    assign take       = i_in_valid && !o_in_stall;

    // reversal swaps the sentinels and the two tables
    assign head = r_rev ? TAIL_KEY : HEAD_KEY;
    assign tail = r_rev ? HEAD_KEY : TAIL_KEY;
    assign fw_q = r_rev ? r_q_prev : r_q_next;
    assign bw_q = r_rev ? r_q_next : r_q_prev;

    always_comb begin
        unique case (i_in_data.kind)
            K_ADDLAST:               rd_x = tail;
            K_ADDFIRST:              rd_x = head;
            K_ADDAFTER, K_ADDBEFORE: rd_x = i_in_data.anchor;
            K_READ:  rd_x = (i_in_data.key == HEAD_KEY) ? head : i_in_data.key;
            default: rd_x = i_in_data.key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind   <= i_in_data.kind;
            r_key    <= i_in_data.key;
            r_anchor <= i_in_data.anchor;
            r_x      <= rd_x;
        end
    end

    assign key_ok = (r_key != HEAD_KEY) && (r_key < TAIL_KEY);
    assign anc_ok = (r_anchor != HEAD_KEY) && (r_anchor < TAIL_KEY) && r_q_pa;
    assign is_rm  = (r_kind == K_REMOVE);

    always_comb begin
        dec_status = ST_APPLIED;
        dec_succ   = '0;
        unique case (r_kind)
            K_ADDLAST, K_ADDFIRST: begin
                priority if (!key_ok) dec_status = ST_REJECTED;
                else if (r_q_pk)      dec_status = ST_IGNORED;
                else                  dec_status = ST_APPLIED;
            end
            K_ADDAFTER, K_ADDBEFORE: begin
                priority if (!key_ok) dec_status = ST_REJECTED;
                else if (r_q_pk)      dec_status = ST_IGNORED;
                else if (!anc_ok)     dec_status = ST_IGNORED;
                else                  dec_status = ST_APPLIED;
            end
            K_REMOVE: begin
                priority if (!key_ok) dec_status = ST_REJECTED;
                else if (!r_q_pk)     dec_status = ST_IGNORED;
                else                  dec_status = ST_APPLIED;
            end
            K_REVERSE: begin
                dec_status = ST_APPLIED;
            end
            K_READ: begin
                dec_succ = TAIL_KEY;
                priority if (r_key >= TAIL_KEY)              dec_status = ST_REJECTED;
                else if (r_key != HEAD_KEY && !r_q_pk)       dec_status = ST_IGNORED;
                else dec_succ = (fw_q != tail) ? fw_q : TAIL_KEY;
            end
            default: begin
                dec_status = ST_IGNORED;
            end
        endcase
    end

    always_comb begin
        unique case (r_kind)
            K_ADDLAST, K_ADDBEFORE: begin
                dec_b = bw_q;
                dec_a = r_x;
            end
            K_REMOVE: begin
                dec_b = bw_q;
                dec_a = fw_q;
            end
            default: begin
                dec_b = r_x;
                dec_a = fw_q;
            end
        endcase
    end

    assign o_flags.take     = take;
    assign o_flags.skip     = (r_kind > K_REMOVE) || (dec_status != ST_APPLIED);
    assign o_flags.remove   = is_rm;
    assign o_flags.clr_last = (r_clr == TAIL_KEY);

    always_ff @(posedge i_clk) begin
        if (i_uop.decide) begin
            r_b   <= dec_b;
            r_a   <= dec_a;
            r_res <= '{status: dec_status, successor: dec_succ};
        end
    end

    // outer links: remove closes the gap, insert points both neighbours at the key
    assign d_fw = is_rm ? r_a : r_key;
    assign d_bw = is_rm ? r_b : r_key;

    always_comb begin
        next_we = 1'b0;
        next_wa = r_key;
        next_wd = r_a;
        prev_we = 1'b0;
        prev_wa = r_key;
        prev_wd = r_b;
        pres_we = 1'b0;
        pres_wa = r_key;
        pres_wd = 1'b0;
        unique case (i_uop.wsel)
            W_OUTER: begin
                next_we = 1'b1;
                next_wa = r_rev ? r_a : r_b;
                next_wd = r_rev ? d_bw : d_fw;
                prev_we = 1'b1;
                prev_wa = r_rev ? r_b : r_a;
                prev_wd = r_rev ? d_fw : d_bw;
                pres_we = 1'b1;
                pres_wa = r_key;
                pres_wd = !is_rm;
            end
            W_SELF: begin
                next_we = 1'b1;
                next_wa = r_key;
                next_wd = r_rev ? r_b : r_a;
                prev_we = 1'b1;
                prev_wa = r_key;
                prev_wd = r_rev ? r_a : r_b;
            end
            W_CLEAR: begin
                next_we = 1'b1;
                next_wa = r_clr;
                next_wd = TAIL_KEY;
                prev_we = 1'b1;
                prev_wa = r_clr;
                prev_wd = HEAD_KEY;
                pres_we = 1'b1;
                pres_wa = r_clr;
                pres_wd = 1'b0;
            end
            default: begin
                next_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q_next <= r_next_mem[rd_x];
        end
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q_prev <= r_prev_mem[rd_x];
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q_pk <= r_pres_mem[i_in_data.key];
            r_q_pa <= r_pres_mem[i_in_data.anchor];
        end
        if (pres_we) begin
            r_pres_mem[pres_wa] <= pres_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out_data <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_rev       <= 1'b0;
            r_clr       <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_pend;
            end
            if (i_uop.decide) begin
                r_pend <= 1'b1;
            end else if (out_free) begin
                r_pend <= 1'b0;
            end
            if (i_uop.decide && r_kind == K_REVERSE) begin
                r_rev <= ~r_rev;
            end
            if (i_uop.wsel == W_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hw/rtl/keyed_doubly_linked_list_unit.sv @@
// Result path: the input word and table reads are registered at fetch, the decision
// at decide, and the result word enters the output register once that register is free.
// Steps: an applied add runs fetch, decide, outer and self, an applied remove fetch,
// decide and outer, and anything else fetch and decide. Words are taken only at fetch.
// Reset: synchronous, active low; a clearing pass then covers all KEYS (1024) entries
// of the tables and the membership memory with the input stalled.
module keyed_doubly_linked_list_unit import kdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_uop   uop;
    t_flags flags;

    kdll_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    kdll_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (uop),
        .o_flags     (flags),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hw/rtl/kdll_checker.sv @@
`include "keyed_doubly_linked_list_unit_assert.svh"

module kdll_checker import kdll_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    `KDLL_ASSERT_SAME(a_clear_stalls, $past(!i_rst_n), o_in_stall, "input taken during clear")
    `KDLL_ASSERT_NEXT(a_one_at_a_time, in_acc, o_in_stall, "second word taken while busy")
    `KDLL_ASSERT_NEXT(a_result_due, in_acc ##2 !i_out_stall, o_out_valid, "result word late")
    `KDLL_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result word changed")

endmodule

bind keyed_doubly_linked_list_unit kdll_checker u_kdll_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import kdll_pkg::*;

    localparam logic [2:0] K_UNUSED  = 3'd7;
    localparam int         LIMIT     = 200000;
    localparam int         N_RANDOM  = 1250;
    localparam int         POOL_HIGH = 48;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_word = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    keyed_doubly_linked_list_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // list model
    logic [KEY_W-1:0] succ_tab [KEYS];
    logic [KEY_W-1:0] pred_tab [KEYS];
    bit               member   [KEYS];
    bit               flipped;

    // stimulus shadow: membership only
    bit               shadow_in [KEYS];
    int               shadow_keys [$];

    t_in  pending_words  [$];
    t_out expected_words [$];
    t_out want;

    int   errors = 0;
    int   words_taken = 0;
    int   cycles = 0;
    int   results_seen = 0;
    int   by_status [4];
    logic steady;

    assign steady = words_taken >= 500 && words_taken < 800;

    function automatic logic [KEY_W-1:0] fw_get(logic [KEY_W-1:0] i);
        return flipped ? pred_tab[i] : succ_tab[i];
    endfunction

    function automatic logic [KEY_W-1:0] bw_get(logic [KEY_W-1:0] i);
        return flipped ? succ_tab[i] : pred_tab[i];
    endfunction

    function automatic void fw_set(logic [KEY_W-1:0] i, logic [KEY_W-1:0] v);
        if (flipped) pred_tab[i] = v;
        else succ_tab[i] = v;
    endfunction

    function automatic void bw_set(logic [KEY_W-1:0] i, logic [KEY_W-1:0] v);
        if (flipped) succ_tab[i] = v;
        else pred_tab[i] = v;
    endfunction

    function automatic t_out apply_list_op(t_in w);
        logic [KEY_W-1:0] hd, tl, k, v, b, a, s;
        bit               key_ok, anchor_ok;
        t_out             r;
        r.status    = ST_APPLIED;
        r.successor = '0;
        k  = w.key;
        v  = w.anchor;
        hd = flipped ? TAIL_KEY : HEAD_KEY;
        tl = flipped ? HEAD_KEY : TAIL_KEY;
        key_ok    = k != HEAD_KEY && k != TAIL_KEY;
        anchor_ok = v != HEAD_KEY && v != TAIL_KEY && member[v];
        if (w.kind <= K_REMOVE) begin
            if (!key_ok) begin
                r.status = ST_REJECTED;
            end else if (w.kind == K_REMOVE) begin
                if (!member[k]) begin
                    r.status = ST_IGNORED;
                end else begin
                    b = bw_get(k);
                    a = fw_get(k);
                    member[k] = 1'b0;
                    fw_set(b, a);
                    bw_set(a, b);
                end
            end else if (member[k]) begin
                r.status = ST_IGNORED;
            end else if ((w.kind == K_ADDAFTER || w.kind == K_ADDBEFORE) && !anchor_ok) begin
                r.status = ST_IGNORED;
            end else begin
                member[k] = 1'b1;
                case (w.kind)
                    K_ADDLAST: begin
                        b = bw_get(tl);
                        a = tl;
                    end
                    K_ADDFIRST: begin
                        b = hd;
                        a = fw_get(hd);
                    end
                    K_ADDAFTER: begin
                        b = v;
                        a = fw_get(v);
                    end
                    default: begin
                        b = bw_get(v);
                        a = v;
                    end
                endcase
                fw_set(b, k);
                bw_set(a, k);
                bw_set(k, b);
                fw_set(k, a);
            end
        end else if (w.kind == K_REVERSE) begin
            flipped = !flipped;
        end else if (w.kind == K_READ) begin
            r.successor = TAIL_KEY;
            if (k == TAIL_KEY) begin
                r.status = ST_REJECTED;
            end else if (k != HEAD_KEY && !member[k]) begin
                r.status = ST_IGNORED;
            end else begin
                s = fw_get(k == HEAD_KEY ? hd : k);
                r.successor = (s == tl) ? TAIL_KEY : s;
            end
        end else begin
            r.status = ST_IGNORED;
        end
        return r;
    endfunction

    task automatic push_word(logic [2:0] kind, logic [KEY_W-1:0] key,
                             logic [KEY_W-1:0] anchor);
        t_in w;
        bit  key_ok;
        w.kind   = kind;
        w.key    = key;
        w.anchor = anchor;
        pending_words.push_back(w);
        key_ok = key != HEAD_KEY && key != TAIL_KEY;
        if (kind <= K_ADDBEFORE && key_ok && !shadow_in[key]) begin
            if (kind <= K_ADDFIRST || (anchor != HEAD_KEY && anchor != TAIL_KEY
                                       && shadow_in[anchor])) begin
                shadow_in[key] = 1'b1;
                shadow_keys.push_back(key);
            end
        end else if (kind == K_REMOVE && key_ok && shadow_in[key]) begin
            shadow_in[key] = 1'b0;
            foreach (shadow_keys[i]) begin
                if (shadow_keys[i] == key) begin
                    shadow_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic logic [KEY_W-1:0] any_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return KEY_W'($urandom_range(1, POOL_HIGH));
        if (r < 95) return KEY_W'($urandom_range(1, KEYS - 2));
        return KEY_W'($urandom_range(0, KEYS - 1));
    endfunction

    function automatic logic [KEY_W-1:0] live_key(int pct);
        if (shadow_keys.size() == 0 || $urandom_range(0, 99) >= pct) return any_key();
        return KEY_W'(shadow_keys[$urandom_range(0, shadow_keys.size() - 1)]);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_words.push_back(apply_list_op(in_word));
                words_taken <= words_taken + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: status %0d successor %0d",
                       o_out_data.status, o_out_data.successor);
                errors++;
            end else begin
                want = expected_words.pop_front();
                by_status[want.status]++;
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.successor !== want.successor) begin
                    $error("successor: expected %0d, got %0d",
                           want.successor, o_out_data.successor);
                    errors++;
                end
            end
        end
        out_stall <= !steady && ($urandom_range(0, 99) < 24);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int r;
        for (int i = 0; i < KEYS; i++) begin
            succ_tab[i]  = '0;
            pred_tab[i]  = '0;
            member[i]    = 1'b0;
            shadow_in[i] = 1'b0;
        end
        succ_tab[HEAD_KEY] = TAIL_KEY;
        pred_tab[TAIL_KEY] = HEAD_KEY;
        flipped = 1'b0;

        push_word(K_READ, 10'd0, 10'd0);
        push_word(K_ADDLAST, 10'd0, 10'd0);
        push_word(K_ADDLAST, 10'd1023, 10'd0);
        push_word(K_REMOVE, 10'd5, 10'd0);
        push_word(K_READ, 10'd1023, 10'd0);
        push_word(K_READ, 10'd5, 10'd0);
        push_word(K_UNUSED, 10'd1023, 10'd1023);
        push_word(K_ADDLAST, 10'd1, 10'd0);
        push_word(K_ADDFIRST, 10'd2, 10'd0);
        push_word(K_ADDAFTER, 10'd3, 10'd1);
        push_word(K_ADDBEFORE, 10'd4, 10'd2);
        push_word(K_ADDAFTER, 10'd5, 10'd0);
        push_word(K_ADDBEFORE, 10'd6, 10'd1023);
        push_word(K_ADDAFTER, 10'd7, 10'd9);
        push_word(K_ADDLAST, 10'd1, 10'd0);
        push_word(K_ADDLAST, 10'd1022, 10'd0);
        push_word(K_ADDAFTER, 10'd512, 10'd1022);
        push_word(K_REVERSE, 10'd0, 10'd0);
        push_word(K_READ, 10'd0, 10'd0);
        push_word(K_READ, 10'd1022, 10'd0);
        push_word(K_ADDLAST, 10'd8, 10'd0);
        push_word(K_ADDFIRST, 10'd9, 10'd0);
        push_word(K_REMOVE, 10'd1, 10'd0);
        push_word(K_REVERSE, 10'd0, 10'd0);
        push_word(K_READ, 10'd0, 10'd0);

        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (shadow_keys.size() > 40 && r < 54) r = 60;
            if (r < 20)      push_word(K_ADDLAST, any_key(), any_key());
            else if (r < 30) push_word(K_ADDFIRST, any_key(), any_key());
            else if (r < 42) push_word(K_ADDAFTER, any_key(), live_key(90));
            else if (r < 54) push_word(K_ADDBEFORE, any_key(), live_key(90));
            else if (r < 68) push_word(K_REMOVE, live_key(85), any_key());
            else if (r < 72) push_word(K_REVERSE, any_key(), any_key());
            else if (r < 80) push_word(K_READ, 10'd0, any_key());
            else if (r < 92) push_word(K_READ, live_key(80), any_key());
            else push_word(3'($urandom_range(0, 7)), KEY_W'($urandom_range(0, KEYS - 1)),
                           KEY_W'($urandom_range(0, KEYS - 1)));
        end

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        while (pending_words.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("testbench: %0d words through the list, %0d results checked", words_taken,
                 results_seen);
        $display("testbench: applied %0d, ignored %0d, rejected %0d",
                 by_status[ST_APPLIED], by_status[ST_IGNORED], by_status[ST_REJECTED]);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/kdll_pkg.sv
hw/rtl/kdll_seq.sv
hw/rtl/kdll_dp.sv
hw/rtl/keyed_doubly_linked_list_unit.sv
hw/rtl/kdll_checker.sv
dv/testbench.sv
